### design/svmc_pkg.sv
// ----------------------------------------------------------------------------
// svmc_pkg
// shared types, constants and fixed-point helpers of the stereo compressor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svmc_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_INPUT_GAIN   = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_RELEASE_COEF = 3'd2;
  localparam logic [2:0] REG_FASTEST_COEF = 3'd3;
  localparam logic [2:0] REG_FINAL_GAIN   = 3'd4;
  localparam logic [2:0] REG_WET_MIX      = 3'd5;
  localparam logic [2:0] REG_OUTPUT_LEVEL = 3'd6;
  localparam logic [2:0] REG_BYPASS       = 3'd7;

  localparam logic [31:0] ONE14       = 32'd16384;
  localparam logic [31:0] ONE30       = 32'd1073741824;
  localparam logic [31:0] SPEED_RST   = 32'd163840000;
  localparam logic [23:0] DETECT_GAIN = 24'd4174456;
  localparam logic [23:0] TRIM_GAIN   = 24'd263390;
  localparam logic [22:0] GAIN_ONE22  = 23'd4194304;
  localparam logic [16:0] WET_FULL    = 17'd65536;

  // width of the rounding and clamping helpers
  localparam int RND_W = 80;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DRY, ST_DET, ST_SQ, ST_BR, ST_VARY_W, ST_SQRT_W, ST_CDIV_W,
    ST_NUM, ST_SDIV_W, ST_GAIN, ST_W1, ST_W2, ST_W3, ST_M1, ST_M2, ST_OUT,
    ST_DONE
  } svmc_state_e;

  typedef struct packed {
    logic        start;
    logic        sqrt;
    logic [63:0] num;
    logic [63:0] den;
  } svmc_du_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
  } svmc_du_rsp_t;

  // shift right by n, rounding half away from zero
  function automatic logic signed [RND_W-1:0] rshr(input logic signed [RND_W-1:0] x,
                                                    input int unsigned n);
    logic [RND_W-1:0] mag;
    logic [RND_W-1:0] r;
    mag = x[RND_W-1] ? RND_W'(-x) : RND_W'(x);
    r = (mag + (RND_W'(1) << (n - 1))) >> n;
    rshr = x[RND_W-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [RND_W-1:0] clamp(input logic signed [RND_W-1:0] x,
                                                     input logic signed [RND_W-1:0] lo,
                                                     input logic signed [RND_W-1:0] hi);
    clamp = (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

endpackage

`default_nettype wire

### design/svmc_divsqrt.sv
// ----------------------------------------------------------------------------
// svmc_divsqrt
// shared radix-2 unsigned divider and integer square root, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svmc_divsqrt import svmc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire svmc_du_req_t req_i,
  output svmc_du_rsp_t      rsp_o
);

  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q;
  logic        sqrt_q, busy_q, done_q;

  logic [64:0] t;
  logic [64:0] lhs, rhs;
  logic [65:0] diff;
  logic        ge;

  always_comb begin
    t    = {rem_q[63:0], quo_q[63]};
    lhs  = sqrt_q ? rem_q : t;
    rhs  = sqrt_q ? ({1'b0, quo_q} + {1'b0, den_q}) : {1'b0, den_q};
    diff = {1'b0, lhs} - {1'b0, rhs};
    ge   = !diff[65];
    if (req_i.start) begin
      rem_d = req_i.sqrt ? {1'b0, req_i.num} : 65'd0;
      quo_d = req_i.sqrt ? 64'd0 : req_i.num;
      den_d = req_i.sqrt ? (64'd1 << 62) : req_i.den;
    end else if (sqrt_q) begin
      rem_d = ge ? diff[64:0] : rem_q;
      quo_d = ge ? ((quo_q >> 1) + den_q) : (quo_q >> 1);
      den_d = den_q >> 2;
    end else begin
      rem_d = ge ? diff[64:0] : t;
      quo_d = {quo_q[62:0], ge};
      den_d = den_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
      sqrt_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        sqrt_q <= req_i.sqrt;
        cnt_q  <= req_i.sqrt ? 7'd32 : 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start || busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      den_q <= den_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = quo_q;

endmodule

`default_nettype wire

### design/stereo_vari_mu_compressor.sv
// ----------------------------------------------------------------------------
// stereo_vari_mu_compressor
// two-bank vari-mu style stereo compressor, fixed point, one shared multiplier
// ----------------------------------------------------------------------------
// flow: one word at a time; no new word is taken until the current one is loaded
//   into the output register; an attacking channel adds a divide and a square
//   root, bypass skips the processing; each divide takes 64 steps
// reset: config registers take their defaults, both banks hold coef 1.0 and
//   speed 10000, previous samples are zero, bank b is used first
`timescale 1ns / 1ps
`default_nettype none

module stereo_vari_mu_compressor import svmc_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_sample_i,
  // output words
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      left_out_o,
  output logic signed [SAMPLE_BITS-1:0]      right_out_o,
  output logic [22:0]                        left_gain_o,
  output logic [22:0]                        right_gain_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = (SB + 9 > 33) ? SB + 9 : 33;  // multiplier port a
  localparam int PW    = AW + 33;                      // product width
  localparam int SQ_SH = SB - 16;

  localparam logic signed [RND_W-1:0] DMAX = (RND_W'(1) << (SB + 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] DMIN = -DMAX - RND_W'(1);
  localparam logic signed [RND_W-1:0] MMAX = (RND_W'(1) << (SB + 7)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] MMIN = -MMAX - RND_W'(1);
  localparam logic signed [RND_W-1:0] OMAX = (RND_W'(1) << (SB - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] OMIN = -OMAX - RND_W'(1);

  // config registers
  logic [23:0] input_gain_q, final_gain_q, output_level_q;
  logic [31:0] threshold_q, release_coef_q, fastest_coef_q;
  logic [16:0] wet_mix_q;
  logic        bypass_q;

  // compressor state
  logic [31:0]          coef_a_q [2];
  logic [31:0]          coef_b_q [2];
  logic [31:0]          spd_a_q  [2];
  logic [31:0]          spd_b_q  [2];
  logic signed [SB+1:0] prev_q   [2];
  logic                 bank_q;

  // sequencer and working registers
  svmc_state_e state_q, state_d;
  logic                 ch_q;
  logic signed [SB-1:0] x_q [2];
  logic signed [SB+3:0] dry_q;
  logic signed [SB+1:0] det_q;
  logic [31:0]          sq_q, c_q, s_q, target_q;
  logic                 neg_q;
  logic [25:0]          g22_q;
  logic signed [SB+8:0] w_q;
  logic signed [PW-1:0] acc_q;
  logic signed [SB+7:0] m_q;
  logic signed [SB-1:0] res_out_q  [2];
  logic [22:0]          res_gain_q [2];

  // output register
  logic                 out_valid_q;
  logic signed [SB-1:0] out_l_q, out_r_q;
  logic [22:0]          out_lg_q, out_rg_q;

  // shared multiplier
  logic signed [AW-1:0] mul_a;
  logic signed [32:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic signed [RND_W-1:0] prod_w;

  svmc_du_req_t du_req;
  svmc_du_rsp_t du_rsp;

  logic        in_acc, out_take, out_load;
  logic [16:0] wm_eff;

  // detector pick and square operand
  logic [SB+1:0]  mag_det, mag_prev, mag_pick;
  logic [SB+9:0]  mag_sh;
  logic [25:0]    mq;
  logic [RND_W-1:0] sq_w;

  // divider results and other derived values
  logic [49:0]  s2;
  logic [25:0]  att;
  logic [31:0]  vary_tgt;
  logic [34:0]  spd_num;
  logic signed [67:0] ncw, nsw;
  logic [31:0]  nc, ns;
  logic [34:0]  gsum;
  logic signed [RND_W-1:0] mix_w, out_w;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign wm_eff   = (wet_mix_q > WET_FULL) ? WET_FULL : wet_mix_q;

  svmc_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (du_req),
    .rsp_o  (du_rsp)
  );

  // detector: square whichever of current and previous has the smaller magnitude
  always_comb begin
    mag_det  = det_q[SB+1] ? (SB+2)'(-det_q) : (SB+2)'(det_q);
    mag_prev = prev_q[ch_q][SB+1] ? (SB+2)'(-prev_q[ch_q]) : (SB+2)'(prev_q[ch_q]);
    mag_pick = (mag_det > mag_prev) ? mag_prev : mag_det;
    mag_sh   = {mag_pick, 8'b0};
    mq       = 26'(mag_sh >> SQ_SH);
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DRY:  begin mul_a = AW'(x_q[ch_q]);      mul_b = 33'(input_gain_q);  end
      ST_DET:  begin mul_a = AW'(dry_q);          mul_b = 33'(DETECT_GAIN);   end
      ST_SQ:   begin mul_a = AW'({1'b0, mq});     mul_b = 33'(mq);            end
      ST_BR:   begin mul_a = AW'({1'b0, s_q});    mul_b = 33'(s_q);           end
      ST_NUM:  begin mul_a = AW'({1'b0, sq_q});   mul_b = 33'(release_coef_q); end
      ST_GAIN: begin mul_a = AW'({1'b0, c_q});    mul_b = 33'(c_q);           end
      ST_W1:   begin mul_a = AW'(det_q);          mul_b = 33'(g22_q);         end
      ST_W2:   begin mul_a = AW'(w_q);            mul_b = 33'(TRIM_GAIN);     end
      ST_W3:   begin mul_a = AW'(w_q);            mul_b = 33'(final_gain_q);  end
      ST_M1:   begin mul_a = AW'(dry_q);          mul_b = 33'(WET_FULL - wm_eff); end
      ST_M2:   begin mul_a = AW'(w_q);            mul_b = 33'(wm_eff);        end
      ST_OUT:  begin mul_a = AW'(m_q);            mul_b = 33'(output_level_q); end
      default: begin mul_a = '0;                  mul_b = '0;                 end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_w = RND_W'(prod);

  // derived values of the recursions
  always_comb begin
    sq_w     = (RND_W'(prod[63:0]) + RND_W'(32768)) >> 16;
    s2       = (prod[63:14] < 50'(ONE14)) ? 50'(ONE14) : prod[63:14];
    att      = (26'(du_rsp.res[23:0]) << 2) + 26'(du_rsp.res[23:0]);
    att      = (att < 26'(ONE14)) ? 26'(ONE14) : att;
    vary_tgt = (du_rsp.res < 64'(threshold_q)) ? threshold_q : du_rsp.res[31:0];
    spd_num  = 35'(prod[63:30]) + 35'(fastest_coef_q >> 8);
    ncw      = neg_q ? ($signed({36'b0, c_q}) - $signed({4'b0, du_rsp.res}))
                     : ($signed({36'b0, c_q}) + $signed({4'b0, du_rsp.res}));
    nc       = (ncw < 0) ? 32'd0 : ((ncw > 68'sh0FFFFFFFF) ? 32'hFFFFFFFF : ncw[31:0]);
    nsw      = $signed({36'b0, s_q}) - $signed({36'b0, ONE14})
             + $signed({4'b0, du_rsp.res});
    ns       = (nsw < $signed({36'b0, ONE14})) ? ONE14
             : ((nsw > 68'sh0FFFFFFFF) ? 32'hFFFFFFFF : nsw[31:0]);
    gsum     = 35'(c_q) + 35'(prod[63:30]);
    mix_w    = clamp(rshr(RND_W'(acc_q) + prod_w, 16), MMIN, MMAX);
    out_w    = clamp(rshr(prod_w, 20), OMIN, OMAX);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = bypass_q ? ST_DONE : ST_DRY;
      ST_DRY:    state_d = ST_DET;
      ST_DET:    state_d = ST_SQ;
      ST_SQ:     state_d = ST_BR;
      ST_BR:     state_d = (sq_q > threshold_q) ? ST_VARY_W : ST_CDIV_W;
      ST_VARY_W: if (du_rsp.done) state_d = ST_SQRT_W;
      ST_SQRT_W: if (du_rsp.done) state_d = ST_CDIV_W;
      ST_CDIV_W: if (du_rsp.done) state_d = ST_NUM;
      ST_NUM:    state_d = ST_SDIV_W;
      ST_SDIV_W: if (du_rsp.done) state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_W1;
      ST_W1:     state_d = ST_W2;
      ST_W2:     state_d = ST_W3;
      ST_W3:     state_d = ST_M1;
      ST_M1:     state_d = ST_M2;
      ST_M2:     state_d = ST_OUT;
      ST_OUT:    state_d = ch_q ? ST_DONE : ST_DRY;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and divider requests
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    du_req.start = 1'b0;
    du_req.sqrt  = 1'b0;
    du_req.num   = '0;
    du_req.den   = '0;
    unique case (state_q)
      ST_BR: begin
        du_req.start = 1'b1;
        if (sq_q > threshold_q) begin
          // varying target: thr / sq as a Q.30 fraction
          du_req.num = 64'({threshold_q, 30'b0});
          du_req.den = 64'(sq_q);
        end else begin
          // release toward 1.0
          du_req.num = (c_q > ONE30) ? 64'(c_q - ONE30) << 14 : 64'(ONE30 - c_q) << 14;
          du_req.den = 64'(s2);
        end
      end
      ST_VARY_W: begin
        // attack divisor needs sqrt of speed
        du_req.start = du_rsp.done;
        du_req.sqrt  = 1'b1;
        du_req.num   = 64'(s_q) << 14;
      end
      ST_SQRT_W: begin
        du_req.start = du_rsp.done;
        du_req.num   = (c_q > target_q) ? 64'(c_q - target_q) << 14
                                        : 64'(target_q - c_q) << 14;
        du_req.den   = 64'(att);
      end
      ST_NUM: begin
        // speed update term
        du_req.start = 1'b1;
        du_req.num   = 64'(spd_num) << 14;
        du_req.den   = 64'(s_q);
      end
      default: begin
        du_req.start = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) ch_q <= 1'b0;
      else if (state_q == ST_OUT) ch_q <= 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_take) out_valid_q <= 1'b0;
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_gain_q   <= 24'd1048576;
      threshold_q    <= 32'd550829556;
      release_coef_q <= 32'd13510099;
      fastest_coef_q <= 32'd120443000;
      final_gain_q   <= 24'd1048576;
      wet_mix_q      <= WET_FULL;
      output_level_q <= 24'd1048576;
      bypass_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_INPUT_GAIN:   input_gain_q   <= cfg_data_i[23:0];
        REG_THRESHOLD:    threshold_q    <= cfg_data_i;
        REG_RELEASE_COEF: release_coef_q <= cfg_data_i;
        REG_FASTEST_COEF: fastest_coef_q <= cfg_data_i;
        REG_FINAL_GAIN:   final_gain_q   <= cfg_data_i[23:0];
        REG_WET_MIX:      wet_mix_q      <= cfg_data_i[16:0];
        REG_OUTPUT_LEVEL: output_level_q <= cfg_data_i[23:0];
        REG_BYPASS:       bypass_q       <= cfg_data_i[0];
        default:          bypass_q       <= bypass_q;
      endcase
    end
  end

  // bank state and detector history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        coef_a_q[i] <= ONE30;
        coef_b_q[i] <= ONE30;
        spd_a_q[i]  <= SPEED_RST;
        spd_b_q[i]  <= SPEED_RST;
        prev_q[i]   <= '0;
      end
      bank_q <= 1'b0;
    end else begin
      if (state_q == ST_SQ) prev_q[ch_q] <= det_q;
      if (state_q == ST_SDIV_W && du_rsp.done) begin
        if (bank_q) begin
          coef_a_q[ch_q] <= c_q;
          spd_a_q[ch_q]  <= ns;
        end else begin
          coef_b_q[ch_q] <= c_q;
          spd_b_q[ch_q]  <= ns;
        end
      end
      // banks alternate after each word that is not bypassed
      if (state_q == ST_OUT && ch_q) bank_q <= !bank_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q[0] <= left_sample_i;
      x_q[1] <= right_sample_i;
      // bypass results are the inputs themselves
      res_out_q[0]  <= left_sample_i;
      res_out_q[1]  <= right_sample_i;
      res_gain_q[0] <= GAIN_ONE22;
      res_gain_q[1] <= GAIN_ONE22;
    end
    unique case (state_q)
      ST_DRY: dry_q <= (SB+4)'(rshr(prod_w, 20));
      ST_DET: det_q <= (SB+2)'(clamp(rshr(prod_w, 20), DMIN, DMAX));
      ST_SQ: begin
        sq_q <= (sq_w > RND_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : sq_w[31:0];
        c_q  <= bank_q ? coef_a_q[ch_q] : coef_b_q[ch_q];
        s_q  <= ((bank_q ? spd_a_q[ch_q] : spd_b_q[ch_q]) < ONE14) ? ONE14
              : (bank_q ? spd_a_q[ch_q] : spd_b_q[ch_q]);
      end
      ST_BR: neg_q <= (c_q > ONE30);
      ST_VARY_W: if (du_rsp.done) target_q <= vary_tgt;
      ST_SQRT_W: if (du_rsp.done) neg_q <= (c_q > target_q);
      ST_CDIV_W: if (du_rsp.done) c_q <= nc;
      ST_GAIN: g22_q <= gsum[34:9];
      ST_W1:   w_q   <= (SB+9)'(rshr(prod_w, 22));
      ST_W2:   w_q   <= (SB+9)'(rshr(prod_w, 20));
      ST_W3:   w_q   <= (SB+9)'(rshr(prod_w, 20));
      ST_M1:   acc_q <= prod;
      ST_M2:   m_q   <= (SB+8)'(mix_w);
      ST_OUT: begin
        res_out_q[ch_q]  <= SB'(out_w);
        res_gain_q[ch_q] <= (g22_q > 26'(GAIN_ONE22)) ? GAIN_ONE22 : g22_q[22:0];
      end
      default: neg_q <= neg_q;
    endcase
    if (out_load) begin
      out_l_q  <= res_out_q[0];
      out_r_q  <= res_out_q[1];
      out_lg_q <= res_gain_q[0];
      out_rg_q <= res_gain_q[1];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_out_o   = out_l_q;
  assign right_out_o  = out_r_q;
  assign left_gain_o  = out_lg_q;
  assign right_gain_o = out_rg_q;

  // a new word is never taken twice in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while a word is in flight");

  // the shared divider is only started when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    du_req.start |-> !du_rsp.busy)
    else $error("divider started while busy");

  // a result only appears out of the finishing state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("output valid without a finished word");

  // speed of bank a left and bank b right never drops below 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spd_a_q[0] >= ONE14) && (spd_b_q[1] >= ONE14))
    else $error("speed state below floor");

endmodule

`default_nettype wire

### sim/stereo_vari_mu_compressor_tb.sv
// ----------------------------------------------------------------------------
// stereo_vari_mu_compressor_tb
// self-checking bench: a directed set of stereo words, then random words with
// random idle bursts on both sides, across several register settings; every
// output word is checked against a fixed-point predictor of the compressor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_vari_mu_compressor_tb import svmc_pkg::*;;

  localparam int SB = 24;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } pair_t;

  typedef struct packed {
    logic signed [SB-1:0] left_out;
    logic signed [SB-1:0] right_out;
    logic [22:0]          left_gain;
    logic [22:0]          right_gain;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_INPUT_GAIN;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SB-1:0] left_in = '0;
  logic signed [SB-1:0] right_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SB-1:0] left_out, right_out;
  logic [22:0] left_gain, right_gain;

  always #5 clk = ~clk;

  stereo_vari_mu_compressor #(.SAMPLE_BITS(SB)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .left_sample_i(left_in), .right_sample_i(right_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .left_out_o(left_out), .right_out_o(right_out),
    .left_gain_o(left_gain), .right_gain_o(right_gain)
  );

  // predictor copy of the registers and the compressor state
  logic [23:0] p_input_gain, p_final_gain, p_output_level;
  logic [31:0] p_threshold, p_release, p_fastest;
  logic [16:0] p_wet;
  logic        p_bypass;
  logic [31:0] p_coef[2][2];   // [bank][channel], bank 1 is a
  logic [31:0] p_speed[2][2];
  longint      p_prev[2];
  logic        p_bank;

  pair_t   pending_pairs[$];
  result_t expected_words[$];
  int      errors = 0;
  int      checked = 0;
  bit      calm = 1'b0;     // no idling near the end
  longint  cycles = 0;

  function automatic longint rnd_shift(longint x, int n);
    longint unsigned m;
    m = x < 0 ? -x : x;
    m = (m + (64'd1 << (n - 1))) >> n;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // one channel of the level detector and gain cell, returns gain in Q.30
  function automatic longint unsigned detect_gain(int ch, longint det);
    longint pick, nc, ns;
    longint unsigned mag_d, mag_p, m, sq, c, s, thr, vary, tgt, att, s2, num, lo, hi;
    logic b;
    mag_d = det < 0 ? -det : det;
    mag_p = p_prev[ch] < 0 ? -p_prev[ch] : p_prev[ch];
    pick = mag_d > mag_p ? p_prev[ch] : det;
    m = pick < 0 ? -pick : pick;
    m = (m << 8) >> (SB - 16);
    sq = (m * m + 32768) >> 16;
    if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
    b = p_bank;
    c = p_coef[b][ch];
    s = p_speed[b][ch];
    thr = p_threshold;
    p_prev[ch] = det;
    if (s < ONE14) s = ONE14;
    if (sq > thr) begin
      // attack toward the variable limit
      vary = (thr << 30) / sq;
      tgt = vary < thr ? thr : vary;
      att = 5 * int_sqrt(s << 14);
      if (att < ONE14) att = ONE14;
      nc = longint'(c) + (longint'(tgt) - longint'(c)) * 16384 / longint'(att);
    end else begin
      // release toward unity
      s2 = (s * s) >> 14;
      if (s2 < ONE14) s2 = ONE14;
      nc = longint'(c) + (longint'(ONE30) - longint'(c)) * 16384 / longint'(s2);
    end
    nc = sat(nc, 0, 64'hFFFF_FFFF);
    lo = sq * (p_release & 32'hFFFF);
    hi = sq * (p_release >> 16);
    num = ((hi + (lo >> 16)) >> 14) + (p_fastest >> 8);
    ns = longint'(s) - longint'(ONE14) + longint'((num << 14) / s);
    ns = sat(ns, ONE14, 64'hFFFF_FFFF);
    p_coef[b][ch] = nc[31:0];
    p_speed[b][ch] = ns[31:0];
    c = nc;
    return (c + ((c * c) >> 30)) >> 1;
  endfunction

  function automatic result_t compress_pair(pair_t w);
    result_t r;
    longint x, dry, det, wv, mix, o, wm;
    longint unsigned g22;
    for (int ch = 0; ch < 2; ch++) begin
      x = ch == 0 ? longint'(w.left) : longint'(w.right);
      if (p_bypass) begin
        o = x;
        g22 = GAIN_ONE22;
      end else begin
        wm = p_wet > WET_FULL ? WET_FULL : p_wet;
        dry = rnd_shift(x * longint'(p_input_gain), 20);
        det = sat(rnd_shift(dry * longint'(DETECT_GAIN), 20), -(64'd1 << (SB + 1)),
                  (64'd1 << (SB + 1)) - 1);
        g22 = detect_gain(ch, det) >> 8;
        wv = rnd_shift(det * longint'(g22), 22);
        wv = rnd_shift(wv * longint'(TRIM_GAIN), 20);
        wv = rnd_shift(wv * longint'(p_final_gain), 20);
        mix = rnd_shift(dry * (65536 - wm) + wv * wm, 16);
        mix = sat(mix, -(64'd1 << (SB + 7)), (64'd1 << (SB + 7)) - 1);
        o = sat(rnd_shift(mix * longint'(p_output_level), 20), -(64'd1 << (SB - 1)),
                (64'd1 << (SB - 1)) - 1);
        if (g22 > GAIN_ONE22) g22 = GAIN_ONE22;
      end
      if (ch == 0) begin
        r.left_out = o[SB-1:0];
        r.left_gain = g22[22:0];
      end else begin
        r.right_out = o[SB-1:0];
        r.right_gain = g22[22:0];
      end
    end
    if (!p_bypass) p_bank = ~p_bank;
    return r;
  endfunction

  // handshake tracking shared by the driver and the monitor
  logic in_stall_q = 1'b1;
  int out_gap = 0;
  int in_gap = 0;
  result_t got;

  // driver: feeds pending pairs, inputs change on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        // word taken at the last rising edge
        if (in_gap == 0 && !calm && $urandom_range(0, 15) == 0)
          in_gap = $urandom_range(1, 19);
        if (in_gap > 0 || pending_pairs.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          {left_in, right_in} <= pending_pairs.pop_front();
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_pairs.size() != 0) begin
          in_valid <= 1'b1;
          {left_in, right_in} <= pending_pairs.pop_front();
        end
      end
      if (in_gap > 0 && in_valid && !in_stall_q) in_gap--;
      // receiver stall bursts
      if (out_gap > 0) out_gap--;
      else if (!calm && $urandom_range(0, 20) == 0) out_gap = $urandom_range(1, 19);
      out_stall <= (out_gap > 0);
    end
  end

  // accepted-input tracking and output checking at the rising edge
  always @(posedge clk) begin
    cycles++;
    in_stall_q <= in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_words.push_back(compress_pair('{left_in, right_in}));
    if (rst_n && out_valid && !out_stall) begin
      got = '{left_out, right_out, left_gain, right_gain};
      checked++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, got);
        errors++;
      end else if (expected_words[0] != got) begin
        $display("%0t: mismatch exp out %0d/%0d gain %0d/%0d got out %0d/%0d gain %0d/%0d",
                 $realtime, expected_words[0].left_out, expected_words[0].right_out,
                 expected_words[0].left_gain, expected_words[0].right_gain,
                 got.left_out, got.right_out, got.left_gain, got.right_gain);
        errors++;
        void'(expected_words.pop_front());
      end else void'(expected_words.pop_front());
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_INPUT_GAIN:   p_input_gain = val[23:0];
      REG_THRESHOLD:    p_threshold = val;
      REG_RELEASE_COEF: p_release = val;
      REG_FASTEST_COEF: p_fastest = val;
      REG_FINAL_GAIN:   p_final_gain = val[23:0];
      REG_WET_MIX:      p_wet = val[16:0];
      REG_OUTPUT_LEVEL: p_output_level = val[23:0];
      default:          p_bypass = val[0];
    endcase
  endtask

  // wait until the block has drained everything handed to it
  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 255) - 128);     // near silence
      1: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
      2: return $signed(24'($urandom_range(0, 24'hFFFFF))) - 24'sh80000;
      default: return $signed(24'($urandom()));
    endcase
  endfunction

  // a burst of random stereo words, sometimes the same on both sides
  task automatic queue_random(int n);
    logic signed [SB-1:0] l, r;
    for (int i = 0; i < n; i++) begin
      l = rand_sample();
      r = $urandom_range(0, 3) == 0 ? l : rand_sample();
      pending_pairs.push_back('{l, r});
    end
  endtask

  initial begin
    p_input_gain = 24'd1048576; p_threshold = 32'd550829556;
    p_release = 32'd13510099; p_fastest = 32'd120443000;
    p_final_gain = 24'd1048576; p_wet = WET_FULL; p_output_level = 24'd1048576;
    p_bypass = 1'b0; p_bank = 1'b0;
    for (int b = 0; b < 2; b++)
      for (int ch = 0; ch < 2; ch++) begin
        p_coef[b][ch] = ONE30;
        p_speed[b][ch] = SPEED_RST;
      end
    p_prev[0] = 0; p_prev[1] = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, silence, alternating signs, loud run for attack
    pending_pairs.push_back('{24'sh7FFFFF, -24'sh800000});
    pending_pairs.push_back('{-24'sh800000, 24'sh7FFFFF});
    pending_pairs.push_back('{24'sh0, 24'sh0});
    pending_pairs.push_back('{24'sh1, -24'sh1});
    pending_pairs.push_back('{24'sh555555, -24'sh2AAAAB});
    for (int i = 0; i < 8; i++) pending_pairs.push_back('{24'sh700000, -24'sh700000});
    for (int i = 0; i < 4; i++) pending_pairs.push_back('{24'sh10, 24'sh0});
    drain();

    // tiny speeds, zero threshold: small divisors, coefficient jumps
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_RELEASE_COEF, 32'd0);
    write_reg(REG_FASTEST_COEF, 32'd0);
    write_reg(REG_WET_MIX, 32'd131071);   // over full wet
    queue_random(6);
    drain();

    // maximum gains: saturating mix and output, speed ceiling
    write_reg(REG_INPUT_GAIN, 32'hFFFFFF);
    write_reg(REG_FINAL_GAIN, 32'hFFFFFF);
    write_reg(REG_OUTPUT_LEVEL, 32'hFFFFFF);
    write_reg(REG_RELEASE_COEF, 32'hFFFFFFFF);
    write_reg(REG_FASTEST_COEF, 32'hFFFFFFFF);
    write_reg(REG_THRESHOLD, 32'hFFFFFFFF);
    write_reg(REG_WET_MIX, 32'd32768);
    queue_random(6);
    drain();

    // bypass on then off; then zero gains, fully dry
    write_reg(REG_BYPASS, 32'd1);
    queue_random(8);
    pending_pairs.push_back('{24'sh7FFFFF, -24'sh800000});
    drain();
    write_reg(REG_BYPASS, 32'd0);
    write_reg(REG_INPUT_GAIN, 32'd0);
    write_reg(REG_WET_MIX, 32'd0);
    write_reg(REG_OUTPUT_LEVEL, 32'd0);
    write_reg(REG_FINAL_GAIN, 32'd0);
    queue_random(4);
    drain();

    // random phases with random register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_INPUT_GAIN,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(262144, 4194304));
      write_reg(REG_THRESHOLD,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1000000, 1073741824));
      write_reg(REG_RELEASE_COEF,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(100000, 50000000));
      write_reg(REG_FASTEST_COEF,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1000000, 500000000));
      write_reg(REG_FINAL_GAIN,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(262144, 4194304));
      write_reg(REG_WET_MIX,
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 65536));
      write_reg(REG_OUTPUT_LEVEL,
                $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(262144, 4194304));
      write_reg(REG_BYPASS, 32'($urandom_range(0, 7) == 0));
      if (ph == 7) calm = 1'b1;
      queue_random(140);
      drain();
    end

    $display("checked %0d output words over directed and random phases", checked);
    $display("register extremes, bypass, attack and release paths were exercised");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
